### hdl/lss_pkg.sv
package lss_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;
    localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    localparam logic             REG_CAP   = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAITRD,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic rd_top;
        logic srch_init;
        logic srch_step;
        logic srch_hit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            match;
        logic            ptr_zero;
        logic            out_free;
    } stat_t;

endpackage

### hdl/lss_ctrl.sv
module lss_ctrl
    import lss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t sts,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.op) inside
                    OP_POP, OP_PEEK:
                    begin
                        state_next = S_WAITRD;
                    end
                    OP_SEARCH:
                    begin
                        state_next = S_SEARCH;
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_WAITRD, S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (sts.match || sts.ptr_zero)
                begin
                    state_next = S_FINISH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
            end
            S_EXEC:
            begin
                unique case (sts.op) inside
                    OP_POP, OP_PEEK:
                    begin
                        cmd.rd_top = 1'b1;
                    end
                    OP_SEARCH:
                    begin
                        cmd.srch_init = 1'b1;
                    end
                    default:
                    begin
                        cmd.load_out = sts.out_free;
                    end
                endcase
            end
            S_WAITRD, S_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            S_SEARCH:
            begin
                if (sts.match)
                begin
                    cmd.srch_hit = 1'b1;
                end
                else if (!sts.ptr_zero)
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("Result loaded while the output register is occupied.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && sts.match) |=> state_reg == S_FINISH)
        else $error("Search hit did not end the scan.");

endmodule

### hdl/lss_datapath.sv
module lss_datapath
    import lss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    sts,
    input  logic [OP_W-1:0]          op,
    input  logic signed [VAL_W-1:0]  value,
    input  logic [CAP_W-1:0]         cap,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [STAT_W-1:0]        status,
    output logic signed [VAL_W-1:0]  data,
    output logic [IDX_W-1:0]         index,
    output logic [COUNT_W-1:0]       count,
    output logic                     is_full,
    output logic                     is_empty
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [OP_W-1:0]       op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic                  cmp_valid_reg;
    logic [ADDR_W-1:0]     cmp_addr_reg;
    logic                  found_reg;
    logic [ADDR_W-1:0]     hit_addr_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic                     out_valid_reg;
    logic [STAT_W-1:0]        status_reg;
    logic signed [VAL_W-1:0]  data_reg;
    logic [IDX_W-1:0]         index_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    logic                     is_full_reg;
    logic                     is_empty_reg;

    logic [CNT_W-1:0]        cnt_m1;
    logic [CNT_W-1:0]        ptr_m1;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    rd_en;
    logic                    wr_en;
    logic                    full_now;
    logic                    empty_now;
    logic [CNT_W-1:0]        cnt_after;
    logic [STAT_W-1:0]       res_status;
    logic signed [VAL_W-1:0] res_data;
    logic [IDX_W-1:0]        res_idx;

    function automatic logic at_limit(input logic [CNT_W-1:0] cnt,
                                      input logic [CAP_W-1:0] lim);
        return (LIM_W'(cnt) >= LIM_W'(lim)) || (cnt >= CNT_W'(DEPTH));
    endfunction

    assign cnt_m1    = count_reg - CNT_W'(1);
    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign rd_addr   = cmd.rd_top ? cnt_m1[ADDR_W-1:0] : ptr_m1[ADDR_W-1:0];
    assign rd_en     = cmd.rd_top || cmd.srch_step;
    assign full_now  = at_limit(count_reg, cap);
    assign empty_now = (count_reg == '0);

    assign sts.op       = op_reg;
    assign sts.match    = cmp_valid_reg && (rdata_reg == key_reg);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cnt_after  = count_reg;
        res_status = ST_OK;
        res_data   = '0;
        res_idx    = '0;
        wr_en      = 1'b0;
        case (op_reg)
            OP_PUSH:
            begin
                if (full_now)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    wr_en     = cmd.load_out;
                    cnt_after = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty_now)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_data  = VAL_W'(rdata_reg);
                    cnt_after = cnt_m1;
                end
            end
            OP_PEEK:
            begin
                if (empty_now)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_data = VAL_W'(rdata_reg);
                end
            end
            OP_CLEAR:
            begin
                cnt_after = '0;
            end
            OP_SEARCH:
            begin
                if (found_reg)
                begin
                    res_idx = IDX_W'(hit_addr_reg);
                end
                else
                begin
                    res_status = ST_MISS;
                end
            end
            default:
            begin
                cnt_after = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= op;
            key_reg <= DATA_WIDTH'(value);
        end
        if (cmd.srch_step)
        begin
            cmp_addr_reg <= ptr_m1[ADDR_W-1:0];
        end
        if (cmd.srch_hit)
        begin
            hit_addr_reg <= cmp_addr_reg;
        end
        if (cmd.load_out)
        begin
            status_reg    <= res_status;
            data_reg      <= res_data;
            index_reg     <= res_idx;
            count_out_reg <= COUNT_W'(cnt_after);
            is_full_reg   <= at_limit(cnt_after, cap);
            is_empty_reg  <= (cnt_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                count_reg <= cnt_after;
            end
            if (cmd.srch_init)
            begin
                ptr_reg       <= count_reg;
                cmp_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
            end
            else if (cmd.srch_step)
            begin
                ptr_reg       <= ptr_m1;
                cmp_valid_reg <= 1'b1;
            end
            if (cmd.srch_hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign index     = index_reg;
    assign count     = count_out_reg;
    assign is_full   = is_full_reg;
    assign is_empty  = is_empty_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Stack count exceeds the depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && op_reg == OP_PUSH && !full_now)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("Successful push did not advance the count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_step |-> ptr_reg != '0)
        else $error("Search stepped below the bottom entry.");

endmodule

### hdl/lifo_stack_with_search_unit.sv
// Push, clear and unused codes deliver their word from the execute state once the output register is free.
// Pop and peek pass through the execute and read-wait states, the latter for the registered stack memory read.
// Search scans from the top down, reading one entry per cycle, until a match or the bottom entry ends the scan.
// One operation is in flight at a time; a new word is taken while a result waits.
// Reset is asynchronous and active low; it empties the stack and sets the limit to 64.
module lifo_stack_with_search_unit
    import lss_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          op,
    input  logic signed [VAL_W-1:0]  value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [VAL_W-1:0]  data,
    output logic [IDX_W-1:0]         index,
    output logic [COUNT_W-1:0]       count,
    output logic                     is_full,
    output logic                     is_empty,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    logic [CAP_W-1:0] cap_reg;
    logic             cap_sel;
    cmd_t             cmd;
    stat_t            sts;

    assign cap_sel = (paddr[2] == REG_CAP);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    lss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .value     (value),
        .cap       (cap_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .data      (data),
        .index     (index),
        .count     (count),
        .is_full   (is_full),
        .is_empty  (is_empty)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import lss_pkg::*;

    localparam int IDLE_GUARD     = 8;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [PADDR_W-1:0] CAP_ADDR = {REG_CAP, 2'b00};

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [VAL_W-1:0]  data;
        logic [IDX_W-1:0]         index;
        logic [COUNT_W-1:0]       count;
        logic                     is_full;
        logic                     is_empty;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op = OP_PUSH;
    logic signed [VAL_W-1:0]  value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  data;
    logic [IDX_W-1:0]         index;
    logic [COUNT_W-1:0]       count;
    logic                     is_full;
    logic                     is_empty;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    logic signed [VAL_W-1:0]  stack_words [DEPTH];
    int                       stack_depth = 0;
    logic [CAP_W-1:0]         cap_limit = CAP_RESET;

    stack_result_t            expected_results [$];
    int                       mismatches = 0;
    int                       words_sent = 0;
    int                       limits_set = 0;
    int                       full_rejects = 0;
    int                       search_hits = 0;
    int                       quiet_cycles = 0;
    int                       stall_left = 0;
    int                       stall_roll;
    bit                       quiet_tx = 1'b0;
    bit                       quiet_rx = 1'b0;
    int                       sweep_limits [11] = '{2, 5, 17, 32, 63, 64, 65, 100, 1, 0, 127};

    lifo_stack_with_search_unit i_dut (.*);

    always #5 clk = ~clk;

    function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0] o,
                                                     input logic signed [VAL_W-1:0] v);
        stack_result_t r;
        int            lim;
        int            i;
        bit            hit;
        r = '0;
        hit = 1'b0;
        lim = (cap_limit > DEPTH) ? DEPTH : int'(cap_limit);
        case (o)
            OP_PUSH:
                if (stack_depth >= lim || stack_depth >= DEPTH)
                begin
                    r.status = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    stack_words[stack_depth] = v;
                    stack_depth++;
                end
            OP_POP:
                if (stack_depth == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    stack_depth--;
                    r.data = stack_words[stack_depth];
                end
            OP_PEEK:
                if (stack_depth == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = stack_words[stack_depth - 1];
            OP_CLEAR:
                stack_depth = 0;
            OP_SEARCH:
            begin
                for (i = stack_depth; i > 0 && !hit; i--)
                begin
                    if (stack_words[i - 1] == v)
                    begin
                        hit = 1'b1;
                        r.index = IDX_W'(i - 1);
                    end
                end
                if (hit)
                    search_hits++;
                else
                    r.status = ST_MISS;
            end
            default:
                ;
        endcase
        r.count = COUNT_W'(stack_depth);
        r.is_full = (stack_depth >= lim);
        r.is_empty = (stack_depth == 0);
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 8) - 4;
            3:
                if (stack_depth > 0)
                    return stack_words[$urandom_range(0, stack_depth - 1)];
                else
                    return $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [OP_W-1:0] o, input logic [VAL_W-1:0] v);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_stack_op(o, v));
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] lim);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= PDATA_W'(lim);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cap_limit = lim;
        limits_set++;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_W'(lim))
        begin
            $error("capacity_limit: expected %0d, got %0d", lim, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
    endtask

    task automatic run_traffic(input int n, input int push_pct);
        int              roll;
        logic [OP_W-1:0] o;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                o = OP_PUSH;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                    o = OP_POP;
                else if (roll < 50)
                    o = OP_PEEK;
                else if (roll < 90)
                    o = OP_SEARCH;
                else if (roll < 93)
                    o = OP_CLEAR;
                else
                    o = OP_W'($urandom_range(5, 7));
            end
            send_word(o, pick_value());
        end
    endtask

    task automatic test_directed_ops();
        send_word(OP_SEARCH, 32'd0);
        send_word(OP_POP, 32'd0);
        send_word(OP_PEEK, 32'd0);
        send_word(3'd5, 32'hFFFF_FFFF);
        send_word(3'd6, 32'd0);
        send_word(3'd7, 32'h8000_0000);
        send_word(OP_PUSH, 32'h8000_0000);
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_PUSH, 32'd0);
        send_word(OP_PUSH, 32'hFFFF_FFFF);
        send_word(OP_PUSH, 32'h7FFF_FFFF);
        send_word(OP_SEARCH, 32'h7FFF_FFFF);
        send_word(OP_SEARCH, 32'h8000_0000);
        send_word(OP_SEARCH, 32'd12345);
        send_word(OP_PEEK, 32'd0);
        send_word(OP_POP, 32'd0);
        send_word(OP_POP, 32'd0);
        send_word(3'd7, 32'd0);
        send_word(OP_CLEAR, 32'd0);
        send_word(OP_PEEK, 32'd0);
        send_word(OP_CLEAR, 32'd0);
    endtask

    task automatic test_limit_extremes();
        set_capacity(7'd0);
        send_word(OP_PUSH, 32'd5);
        send_word(OP_PEEK, 32'd0);
        send_word(OP_SEARCH, 32'd5);
        set_capacity(7'd1);
        send_word(OP_PUSH, 32'd9);
        send_word(OP_PUSH, 32'd10);
        send_word(OP_SEARCH, 32'd9);
        send_word(OP_POP, 32'd0);
        set_capacity(7'd127);
        run_traffic(110, 85);
        run_traffic(60, 40);
        set_capacity(CAP_RESET);
        run_traffic(120, 55);
    endtask

    task automatic test_limit_lowered();
        set_capacity(7'd64);
        send_word(OP_CLEAR, 32'd0);
        run_traffic(30, 100);
        set_capacity(7'd6);
        send_word(OP_PUSH, 32'd77);
        send_word(OP_PEEK, 32'd0);
        run_traffic(60, 20);
        send_word(OP_PUSH, 32'd78);
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 11; k++)
        begin
            set_capacity(CAP_W'(sweep_limits[k]));
            run_traffic($urandom_range(40, 60), $urandom_range(40, 75));
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (quiet_rx)
            out_stall <= 1'b0;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70)
                out_stall <= 1'b0;
            else if (stall_roll < 95)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        stack_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word arrived with no operation pending");
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    mismatches++;
                end
                if (data !== exp_r.data)
                begin
                    $error("data: expected %0d, got %0d", exp_r.data, data);
                    mismatches++;
                end
                if (index !== exp_r.index)
                begin
                    $error("index: expected %0d, got %0d", exp_r.index, index);
                    mismatches++;
                end
                if (count !== exp_r.count)
                begin
                    $error("count: expected %0d, got %0d", exp_r.count, count);
                    mismatches++;
                end
                if (is_full !== exp_r.is_full)
                begin
                    $error("is_full: expected %0d, got %0d", exp_r.is_full, is_full);
                    mismatches++;
                end
                if (is_empty !== exp_r.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", exp_r.is_empty, is_empty);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_limit_extremes();
        test_limit_lowered();
        test_random_traffic();
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d words under %0d capacity settings.", words_sent, limits_set);
        $display("%0d pushes were refused as full and %0d searches found their key.",
                 full_rejects, search_hits);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hdl/lss_pkg.sv
hdl/lss_ctrl.sv
hdl/lss_datapath.sv
hdl/lifo_stack_with_search_unit.sv
tb/testbench.sv
